// ----- hdl/bps_pkg.sv -----
package bps_pkg;

   localparam int FRAC_BITS_DEF = 14;

   localparam int VEC_W  = 16;            // input component width
   localparam int GAIN_W = 16;            // gain register / radiance width
   localparam int CSR_DW = 32;
   localparam int CSR_AW = 5;

   localparam int HALF_W = VEC_W + 1;     // L+V component
   localparam int NL_W   = 2 * VEC_W;     // N*L product
   localparam int NH_W   = VEC_W + HALF_W; // N*H product
   localparam int HSQ_W  = 2 * HALF_W - 1; // H*H, never negative
   localparam int DNL_W  = NL_W + 2;      // sum of three
   localparam int DNH_W  = NH_W + 2;
   localparam int HH_W   = HSQ_W + 1;     // 34, even
   localparam int SQ_N   = HH_W / 2;      // root bits = root stages
   localparam int SQ_W   = HH_W + 1;      // root work width

   localparam logic [2:0] CSR_DIFF_R = 3'd0;
   localparam logic [2:0] CSR_DIFF_G = 3'd1;
   localparam logic [2:0] CSR_DIFF_B = 3'd2;
   localparam logic [2:0] CSR_SPEC_R = 3'd3;
   localparam logic [2:0] CSR_SPEC_G = 3'd4;
   localparam logic [2:0] CSR_SPEC_B = 3'd5;

endpackage

// ----- hdl/blinn_phong_shader_unit.sv -----
// Channel  | Direction | Word
// req_     | in        | tdata: normal_x,y,z, light_x,y,z, view_x,y,z (16 b each, low first)
// rsp_     | out       | tdata: radiance_r, radiance_g, radiance_b (16 b each, low first)
// csr_     | APB       | gains at byte 0x00..0x14: diff r,g,b then spec r,g,b
//
// One word per cycle sustained while rsp_tready is high or the output register is empty.
// A 17-step square-root pipe and a one-bit-per-stage divider make up most of the pipe.
// Reset clears the gains and all valid bits. A stall on rsp_tready freezes
// the whole pipe; nothing is dropped or duplicated.
module blinn_phong_shader_unit import bps_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // normal_x, normal_y, normal_z, light_x, light_y, light_z, view_x, view_y, view_z
   input  logic [9*VEC_W-1:0]   req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // radiance_r, radiance_g, radiance_b
   output logic [3*GAIN_W-1:0]  rsp_tdata,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [CSR_AW-1:0]    csr_paddr,
   input  logic [CSR_DW-1:0]    csr_pwdata,
   output logic [CSR_DW-1:0]    csr_prdata,
   output logic                 csr_pready
);

   localparam int CW   = FRAC_BITS + 1;                 // cosine width, 0..ONE
   localparam logic [CW-1:0] ONE = CW'(1) << FRAC_BITS;
   localparam int QN   = FRAC_BITS + 1;                 // quotient stages
   localparam int DR_W = (DNH_W > SQ_N + FRAC_BITS + 2) ? DNH_W : SQ_N + FRAC_BITS + 2;
   localparam int PN   = 7;                             // power stages
   localparam int CH_W = GAIN_W + CW + 1;

   // ---------------- config ----------------
   logic [GAIN_W-1:0] dg_ff [3];
   logic [GAIN_W-1:0] sg_ff [3];
   logic [2:0]        csr_idx;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            dg_ff[i] <= '0;
            sg_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DIFF_R: dg_ff[0] <= csr_pwdata[GAIN_W-1:0];
            CSR_DIFF_G: dg_ff[1] <= csr_pwdata[GAIN_W-1:0];
            CSR_DIFF_B: dg_ff[2] <= csr_pwdata[GAIN_W-1:0];
            CSR_SPEC_R: sg_ff[0] <= csr_pwdata[GAIN_W-1:0];
            CSR_SPEC_G: sg_ff[1] <= csr_pwdata[GAIN_W-1:0];
            CSR_SPEC_B: sg_ff[2] <= csr_pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DIFF_R: csr_prdata = CSR_DW'(dg_ff[0]);
         CSR_DIFF_G: csr_prdata = CSR_DW'(dg_ff[1]);
         CSR_DIFF_B: csr_prdata = CSR_DW'(dg_ff[2]);
         CSR_SPEC_R: csr_prdata = CSR_DW'(sg_ff[0]);
         CSR_SPEC_G: csr_prdata = CSR_DW'(sg_ff[1]);
         CSR_SPEC_B: csr_prdata = CSR_DW'(sg_ff[2]);
         default:    csr_prdata = '0;
      endcase
   end

   // ---------------- pipe control ----------------
   logic adv;
   logic out_vld_ff;
   assign adv        = rsp_tready || !out_vld_ff;
   assign req_tready = adv;

   // ---------------- stage A: products ----------------
   logic                     a_vld_ff;
   logic signed [NL_W-1:0]   nl_ff [3], nl_in [3];
   logic signed [NH_W-1:0]   nh_ff [3], nh_in [3];
   logic        [HSQ_W-1:0]  hsq_ff [3], hsq_in [3];

   always_comb begin
      logic signed [VEC_W-1:0]  n, l, v;
      logic signed [HALF_W-1:0] h;
      logic signed [2*HALF_W-1:0] hq;
      for (int i = 0; i < 3; i++) begin
         n  = req_tdata[i*VEC_W +: VEC_W];
         l  = req_tdata[(3+i)*VEC_W +: VEC_W];
         v  = req_tdata[(6+i)*VEC_W +: VEC_W];
         h  = HALF_W'(l) + HALF_W'(v);
         nl_in[i]  = NL_W'(n) * NL_W'(l);
         nh_in[i]  = NH_W'(n) * NH_W'(h);
         hq        = (2*HALF_W)'(h) * (2*HALF_W)'(h);
         hsq_in[i] = hq[HSQ_W-1:0];
      end
   end

   // ---------------- stage B: sums, diffuse cosine ----------------
   logic                     b_vld_ff;
   logic signed [DNH_W-1:0]  b_dnh_ff, b_dnh_in;
   logic        [HH_W-1:0]   b_hh_ff, b_hh_in;
   logic        [CW-1:0]     b_ndl_ff, b_ndl_in;

   always_comb begin
      logic signed [DNL_W-1:0] dnl, sh;
      dnl = DNL_W'(nl_ff[0]) + DNL_W'(nl_ff[1]) + DNL_W'(nl_ff[2]);
      sh  = dnl >>> FRAC_BITS;
      if (dnl <= 0)                    b_ndl_in = '0;
      else if (sh > DNL_W'(ONE))       b_ndl_in = ONE;
      else                             b_ndl_in = sh[CW-1:0];
      b_dnh_in = DNH_W'(nh_ff[0]) + DNH_W'(nh_ff[1]) + DNH_W'(nh_ff[2]);
      b_hh_in  = HH_W'(hsq_ff[0]) + HH_W'(hsq_ff[1]) + HH_W'(hsq_ff[2]);
   end

   // ---------------- square root, one result bit per stage ----------------
   logic                    sq_vld_ff [SQ_N];
   logic [SQ_W-1:0]         sq_v_ff [SQ_N], sq_v_in [SQ_N];
   logic [SQ_W-1:0]         sq_r_ff [SQ_N], sq_r_in [SQ_N];
   logic signed [DNH_W-1:0] sq_dnh_ff [SQ_N], sq_dnh_in [SQ_N];
   logic [CW-1:0]           sq_ndl_ff [SQ_N], sq_ndl_in [SQ_N];

   always_comb begin
      logic [SQ_W-1:0] pv, pr, bitv, t;
      for (int j = 0; j < SQ_N; j++) begin
         if (j == 0) begin
            pv = SQ_W'(b_hh_ff);
            pr = '0;
            sq_dnh_in[j] = b_dnh_ff;
            sq_ndl_in[j] = b_ndl_ff;
         end else begin
            pv = sq_v_ff[j-1];
            pr = sq_r_ff[j-1];
            sq_dnh_in[j] = sq_dnh_ff[j-1];
            sq_ndl_in[j] = sq_ndl_ff[j-1];
         end
         bitv = SQ_W'(1) << (2 * (SQ_N - 1 - j));
         t    = pr + bitv;
         if (pv >= t) begin
            sq_v_in[j] = pv - t;
            sq_r_in[j] = (pr >> 1) + bitv;
         end else begin
            sq_v_in[j] = pv;
            sq_r_in[j] = pr >> 1;
         end
      end
   end

   // ---------------- divide setup ----------------
   logic                d0_vld_ff;
   logic [DR_W-1:0]     d0_rem_ff, d0_rem_in;
   logic [SQ_N-1:0]     d0_r_ff, d0_r_in;
   logic                d0_zero_ff, d0_zero_in;
   logic                d0_sat_ff, d0_sat_in;
   logic [CW-1:0]       d0_ndl_ff;

   always_comb begin
      logic signed [DNH_W-1:0] dnh;
      logic [DR_W:0]           lim;
      dnh        = sq_dnh_ff[SQ_N-1];
      d0_r_in    = sq_r_ff[SQ_N-1][SQ_N-1:0];
      d0_rem_in  = DR_W'(unsigned'(dnh));
      d0_zero_in = (d0_r_in == '0) || (dnh <= 0);
      lim        = ((DR_W+1)'(d0_r_in) << FRAC_BITS) + (DR_W+1)'(d0_r_in);
      d0_sat_in  = (DR_W+1)'(d0_rem_in) >= lim;
   end

   // ---------------- divide, one quotient bit per stage ----------------
   logic             dv_vld_ff [QN];
   logic [DR_W-1:0]  dv_rem_ff [QN], dv_rem_in [QN];
   logic [CW-1:0]    dv_q_ff [QN], dv_q_in [QN];
   logic [SQ_N-1:0]  dv_r_ff [QN], dv_r_in [QN];
   logic             dv_zero_ff [QN], dv_zero_in [QN];
   logic             dv_sat_ff [QN], dv_sat_in [QN];
   logic [CW-1:0]    dv_ndl_ff [QN], dv_ndl_in [QN];

   always_comb begin
      logic [DR_W-1:0] prem, dsh;
      logic [CW-1:0]   pq;
      for (int i = 0; i < QN; i++) begin
         if (i == 0) begin
            prem = d0_rem_ff;
            pq   = '0;
            dv_r_in[i]    = d0_r_ff;
            dv_zero_in[i] = d0_zero_ff;
            dv_sat_in[i]  = d0_sat_ff;
            dv_ndl_in[i]  = d0_ndl_ff;
         end else begin
            prem = dv_rem_ff[i-1];
            pq   = dv_q_ff[i-1];
            dv_r_in[i]    = dv_r_ff[i-1];
            dv_zero_in[i] = dv_zero_ff[i-1];
            dv_sat_in[i]  = dv_sat_ff[i-1];
            dv_ndl_in[i]  = dv_ndl_ff[i-1];
         end
         dsh = DR_W'(dv_r_in[i]) << (FRAC_BITS - i);
         if (prem >= dsh) begin
            dv_rem_in[i] = prem - dsh;
            dv_q_in[i]   = pq | (CW'(1) << (FRAC_BITS - i));
         end else begin
            dv_rem_in[i] = prem;
            dv_q_in[i]   = pq;
         end
      end
   end

   // ---------------- power: ndh^33 ----------------
   logic           pw_vld_ff [PN];
   logic [CW-1:0]  pw_p_ff [PN], pw_p_in [PN];
   logic [CW-1:0]  pw_h_ff [PN], pw_h_in [PN];
   logic [CW-1:0]  pw_ndl_ff [PN], pw_ndl_in [PN];

   always_comb begin
      logic [2*CW-1:0] prod;
      logic [CW-1:0]   ndh;
      if (dv_zero_ff[QN-1])     ndh = '0;
      else if (dv_sat_ff[QN-1]) ndh = ONE;
      else                      ndh = dv_q_ff[QN-1];
      for (int i = 0; i < PN; i++) begin
         if (i == 0) begin
            pw_p_in[i]   = ndh;
            pw_h_in[i]   = ndh;
            pw_ndl_in[i] = dv_ndl_ff[QN-1];
         end else begin
            // squarings, then a last multiply by ndh
            if (i == PN - 1) prod = (2*CW)'(pw_p_ff[i-1]) * (2*CW)'(pw_h_ff[i-1]);
            else             prod = (2*CW)'(pw_p_ff[i-1]) * (2*CW)'(pw_p_ff[i-1]);
            pw_p_in[i]   = prod[FRAC_BITS +: CW];
            pw_h_in[i]   = pw_h_ff[i-1];
            pw_ndl_in[i] = pw_ndl_ff[i-1];
         end
      end
   end

   // ---------------- channel sums, saturation ----------------
   logic               ch_vld_ff;
   logic [CH_W-1:0]    ch_sum_ff [3], ch_sum_in [3];
   logic [GAIN_W-1:0]  out_ff [3], out_in [3];

   always_comb begin
      logic [CH_W+FRAC_BITS-1:0] s;
      for (int c = 0; c < 3; c++) begin
         s = (CH_W+FRAC_BITS)'(dg_ff[c]) * (CH_W+FRAC_BITS)'(pw_ndl_ff[PN-1])
           + (CH_W+FRAC_BITS)'(sg_ff[c]) * (CH_W+FRAC_BITS)'(pw_p_ff[PN-1]);
         ch_sum_in[c] = s[FRAC_BITS +: CH_W];
         out_in[c] = (ch_sum_ff[c] > CH_W'({GAIN_W{1'b1}})) ? {GAIN_W{1'b1}}
                                                             : ch_sum_ff[c][GAIN_W-1:0];
      end
   end

   // ---------------- valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         d0_vld_ff  <= 1'b0;
         ch_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int j = 0; j < SQ_N; j++) sq_vld_ff[j] <= 1'b0;
         for (int i = 0; i < QN; i++)   dv_vld_ff[i] <= 1'b0;
         for (int i = 0; i < PN; i++)   pw_vld_ff[i] <= 1'b0;
      end else if (adv) begin
         a_vld_ff  <= req_tvalid;
         b_vld_ff  <= a_vld_ff;
         for (int j = 0; j < SQ_N; j++) sq_vld_ff[j] <= (j == 0) ? b_vld_ff : sq_vld_ff[j-1];
         d0_vld_ff <= sq_vld_ff[SQ_N-1];
         for (int i = 0; i < QN; i++)   dv_vld_ff[i] <= (i == 0) ? d0_vld_ff : dv_vld_ff[i-1];
         for (int i = 0; i < PN; i++)
            pw_vld_ff[i] <= (i == 0) ? dv_vld_ff[QN-1] : pw_vld_ff[i-1];
         ch_vld_ff  <= pw_vld_ff[PN-1];
         out_vld_ff <= ch_vld_ff;
      end
   end

   // ---------------- data registers ----------------
   always_ff @(posedge clock) begin
      if (adv) begin
         nl_ff  <= nl_in;
         nh_ff  <= nh_in;
         hsq_ff <= hsq_in;
         b_dnh_ff <= b_dnh_in;
         b_hh_ff  <= b_hh_in;
         b_ndl_ff <= b_ndl_in;
         sq_v_ff   <= sq_v_in;
         sq_r_ff   <= sq_r_in;
         sq_dnh_ff <= sq_dnh_in;
         sq_ndl_ff <= sq_ndl_in;
         d0_rem_ff  <= d0_rem_in;
         d0_r_ff    <= d0_r_in;
         d0_zero_ff <= d0_zero_in;
         d0_sat_ff  <= d0_sat_in;
         d0_ndl_ff  <= sq_ndl_ff[SQ_N-1];
         dv_rem_ff  <= dv_rem_in;
         dv_q_ff    <= dv_q_in;
         dv_r_ff    <= dv_r_in;
         dv_zero_ff <= dv_zero_in;
         dv_sat_ff  <= dv_sat_in;
         dv_ndl_ff  <= dv_ndl_in;
         pw_p_ff   <= pw_p_in;
         pw_h_ff   <= pw_h_in;
         pw_ndl_ff <= pw_ndl_in;
         ch_sum_ff <= ch_sum_in;
         out_ff    <= out_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff[2], out_ff[1], out_ff[0]};

endmodule

// ----- tb/tb.sv -----
module tb;
   import bps_pkg::*;

   localparam int FB  = FRAC_BITS_DEF;
   localparam int LAT = 2 + 17 + 1 + (FB + 1) + 7 + 2;
   localparam int WATCHDOG = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [9*VEC_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [3*GAIN_W-1:0] rsp_tdata;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   blinn_phong_shader_unit dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   typedef logic signed [VEC_W-1:0] comp_type;
   typedef struct packed {
      logic [GAIN_W-1:0] b, g, r;
   } rgb_type;

   logic [GAIN_W-1:0] dgain [3];
   logic [GAIN_W-1:0] sgain [3];
   rgb_type radiance_q[$];
   int errors = 0;
   int idle_cnt = 0;
   int send_idle = 0, recv_stall = 0;
   bit hold_rsp = 0;

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
         if (v >= r + bit_v) begin
            v -= r + bit_v;
            r = (r >> 1) + bit_v;
         end else begin
            r >>= 1;
         end
         bit_v >>= 2;
      end
      return r;
   endfunction

   function automatic rgb_type shade(logic [9*VEC_W-1:0] w);
      longint n[3], l[3], h[3];
      longint dnl, dnh;
      logic [63:0] hh, rt, ndl, ndh, spec, s, one;
      logic [GAIN_W-1:0] ch[3];
      rgb_type o;
      one = 64'd1 << FB;
      dnl = 0; dnh = 0; hh = 0;
      for (int i = 0; i < 3; i++) begin
         n[i] = comp_type'(w[i*16 +: 16]);
         l[i] = comp_type'(w[(3+i)*16 +: 16]);
         h[i] = l[i] + longint'(comp_type'(w[(6+i)*16 +: 16]));
         dnl += n[i] * l[i];
         dnh += n[i] * h[i];
         hh += h[i] * h[i];
      end
      if (dnl <= 0) ndl = 0;
      else begin
         ndl = dnl >> FB;
         if (ndl > one) ndl = one;
      end
      rt = int_sqrt(hh);
      if (rt == 0 || dnh <= 0) ndh = 0;
      else begin
         ndh = 64'(dnh) / rt;
         if (ndh > one) ndh = one;
      end
      spec = ndh;
      for (int i = 0; i < 5; i++) spec = (spec * spec) >> FB;
      spec = (spec * ndh) >> FB;
      for (int c = 0; c < 3; c++) begin
         s = (dgain[c] * ndl + sgain[c] * spec) >> FB;
         ch[c] = (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
      end
      o.r = ch[0]; o.g = ch[1]; o.b = ch[2];
      return o;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [CSR_DW-1:0] val);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1;
      csr_paddr <= CSR_AW'(idx) << 2; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx <= CSR_SPEC_B) begin
         if (idx < CSR_SPEC_R) dgain[idx] = val[15:0];
         else sgain[idx - CSR_SPEC_R] = val[15:0];
      end
      @(posedge clock);
   endtask

   task automatic set_gains(logic [15:0] d0, d1, d2, s0, s1, s2);
      csr_write(CSR_DIFF_R, {16'h0, d0});
      csr_write(CSR_DIFF_G, {16'h0, d1});
      csr_write(CSR_DIFF_B, {16'h0, d2});
      csr_write(CSR_SPEC_R, {16'h0, s0});
      csr_write(CSR_SPEC_G, {16'h0, s1});
      csr_write(CSR_SPEC_B, {16'h0, s2});
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (radiance_q.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
   endtask

   // send one word; predicted result pushed at acceptance, or given directly
   task automatic send(logic [9*VEC_W-1:0] w, bit use_exp, rgb_type exp_v);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      radiance_q.push_back(use_exp ? exp_v : shade(w));
   endtask

   function automatic logic [15:0] rnd_comp();
      int k;
      k = $urandom_range(9);
      if (k == 0) return 16'($urandom);
      if (k == 1) return $urandom_range(1) ? 16'h4000 : 16'hC000;
      return 16'($signed($urandom_range(32768)) - 16384);
   endfunction

   function automatic logic [15:0] unit_ish();
      return 16'($signed($urandom_range(23170)) - 11585);
   endfunction

   function automatic logic [9*VEC_W-1:0] pack9(logic [15:0] a, b, c, d, e, f, g, h, i);
      return {i, h, g, f, e, d, c, b, a};
   endfunction

   typedef struct {
      logic [9*VEC_W-1:0] w;
      bit has_exp;
      rgb_type exp_v;
   } row_type;

   row_type dir_rows[$];

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rgb_type got, want;
         got = rsp_tdata;
         if (radiance_q.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = radiance_q.pop_front();
            if (got.r !== want.r) begin
               $display("%0t: radiance_r expected %h actual %h", $time, want.r, got.r);
               errors++;
            end
            if (got.g !== want.g) begin
               $display("%0t: radiance_g expected %h actual %h", $time, want.g, got.g);
               errors++;
            end
            if (got.b !== want.b) begin
               $display("%0t: radiance_b expected %h actual %h", $time, want.b, got.b);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_tready <= 0;
      else if (recv_stall > 0) rsp_tready <= ($urandom_range(99) >= recv_stall);
      else rsp_tready <= 1;
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_psel)
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      rgb_type z, sat;
      z = '0;
      sat = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
      for (int c = 0; c < 3; c++) begin
         dgain[c] = 0; sgain[c] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // gains at reset value: everything shades to zero
      send(pack9(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h4000,
                 16'h0000, 16'h0000, 16'h4000), 1, z);
      drain();
      set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // N=L=V along z: full cosines, both terms max, sum saturates
      dir_rows.push_back('{pack9(0, 0, 16'h4000, 0, 0, 16'h4000, 0, 0, 16'h4000), 1, sat});
      // light behind the surface, L = -V: no diffuse and no specular
      dir_rows.push_back('{pack9(0, 0, 16'h4000, 0, 0, 16'hC000, 0, 0, 16'h4000), 1, z});
      // zero-length half vector with light in front
      dir_rows.push_back('{pack9(16'h4000, 0, 0, 16'h4000, 0, 0, 16'hC000, 0, 0), 0, z});
      // half vector behind surface
      dir_rows.push_back('{pack9(0, 0, 16'h4000, 0, 0, 16'hC000, 0, 0, 16'hC000), 1, z});
      dir_rows.push_back('{pack9(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 16'h8000, 16'h8000, 16'h8000), 0, z});
      dir_rows.push_back('{pack9(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 0, z});
      dir_rows.push_back('{pack9(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0, z});
      dir_rows.push_back('{'0, 1, z});
      dir_rows.push_back('{pack9(16'h2D41, 0, 16'h2D41, 0, 0, 16'h4000, 16'h4000, 0, 0), 0, z});
      dir_rows.push_back('{pack9(16'h8000, 0, 0, 16'h8000, 0, 0, 16'h7FFF, 0, 0), 0, z});
      foreach (dir_rows[i]) send(dir_rows[i].w, dir_rows[i].has_exp, dir_rows[i].exp_v);
      drain();
      set_gains(16'h4000, 16'h2000, 16'h0001, 16'h1000, 16'h8000, 16'h0000);
      send(pack9(0, 0, 16'h4000, 0, 0, 16'h4000, 16'hC000, 0, 0), 0, z);
      // N=L=V: both cosines full, each channel is diffuse gain plus specular gain
      send(pack9(16'h4000, 0, 0, 16'h4000, 0, 0, 16'h4000, 0, 0), 1,
           '{16'h0001, 16'hA000, 16'h5000});
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            3: begin send_idle = 17; recv_stall = 17; end
            4: begin send_idle = 0;  recv_stall = 0;  end
            default: begin send_idle = 17; recv_stall = 48; end
         endcase
         if (ph == 4)
            set_gains(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         else
            set_gains(16'($urandom), 16'($urandom), 16'($urandom_range(16384)),
                      16'($urandom), 16'($urandom_range(16384)), 16'($urandom));
         if (ph == 0) begin
            // long receiver hold while sender keeps offering
            fork
               begin
                  hold_rsp = 1;
                  repeat (300) @(posedge clock);
                  hold_rsp = 0;
               end
            join_none
         end
         for (int k = 0; k < 150; k++) begin
            logic [9*VEC_W-1:0] w;
            if ($urandom_range(3) != 0) begin
               // near-unit vectors, mostly light in front and near view
               w = pack9(unit_ish(), unit_ish(), 16'($urandom_range(16384, 9000)),
                         unit_ish(), unit_ish(), 16'($urandom_range(16384, 9000)),
                         unit_ish(), unit_ish(), 16'($urandom_range(16384, 9000)));
               if ($urandom_range(3) == 0)
                  for (int c = 0; c < 3; c++) w[(6+c)*16 +: 16] = -w[(3+c)*16 +: 16];
            end else begin
               for (int c = 0; c < 9; c++) w[c*16 +: 16] = rnd_comp();
            end
            send(w, 0, z);
            if (k == 75) drain();
         end
         drain();
      end

      if (errors == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end
endmodule
